@@ design/haversine_distance_top_defines.svh @@
// Assertion macros shared by the haversine distance design.
`ifndef HAVERSINE_DISTANCE_TOP_DEFINES_SVH
`define HAVERSINE_DISTANCE_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define HDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define HDC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ design/hdc_pkg.sv @@
// Package with constants, widths and the arctangent table of the haversine distance pipeline.
package hdc_pkg;

	localparam int STEPS_DEF = 24;
	localparam int UW = 40;
	localparam int AW = 32;
	localparam int XW = 34;
	localparam int VW = 61;
	localparam int RW = 31;

	localparam logic [XW-1:0] GAIN = 34'd652032874;
	localparam logic [26:0] RECIP45 = 27'd95443717;
	localparam logic [6:0] DIV45 = 7'd45;
	localparam logic [UW-1:0] BAM_OFS = 40'd386547056640;
	localparam logic [UW-1:0] RND_BIAS = 40'd22;
	localparam logic [26:0] DIST_MUL = 27'd82073634;
	localparam logic [24:0] DIST_MAX = 25'd20518400;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;

	function automatic logic [31:0] atan_at(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ design/hdc_bam.sv @@
// Four-stage conversion of a biased degree value to a binary angle by division by 45.
module hdc_bam (
	input  logic                   clk,
	input  logic [hdc_pkg::UW-1:0] u,
	output logic [hdc_pkg::AW-1:0] bam
);
	import hdc_pkg::*;

	logic [46:0] ph;
	logic [19:0] hi_s2, lo_s2;
	logic [14:0] qe_s2;
	logic [19:0] rh;
	logic [14:0] qh_s3, qh_s4;
	logic [25:0] x2_s3, x2_s4;
	logic [52:0] pl;
	logic [20:0] qle_s4;
	logic [25:0] rl;
	logic [20:0] ql;

	assign ph = 47'(u[39:20]) * 47'(RECIP45);

	always_ff @(posedge clk) begin
		hi_s2 <= u[39:20];
		lo_s2 <= u[19:0];
		qe_s2 <= ph[46:32];
	end

	assign rh = hi_s2 - 20'(qe_s2) * 20'(DIV45);

	always_ff @(posedge clk) begin
		if (rh >= 20'(DIV45)) begin
			qh_s3 <= qe_s2 + 15'd1;
			x2_s3 <= {6'(rh - 20'(DIV45)), lo_s2};
		end else begin
			qh_s3 <= qe_s2;
			x2_s3 <= {rh[5:0], lo_s2};
		end
	end

	assign pl = 53'(x2_s3) * 53'(RECIP45);

	always_ff @(posedge clk) begin
		qh_s4  <= qh_s3;
		x2_s4  <= x2_s3;
		qle_s4 <= pl[52:32];
	end

	assign rl = x2_s4 - 26'(qle_s4) * 26'(DIV45);
	assign ql = (rl >= 26'(DIV45)) ? qle_s4 + 21'd1 : qle_s4;

	always_ff @(posedge clk) begin
		bam <= {qh_s4[11:0], 20'd0} + 32'(ql);
	end

endmodule

@@ design/hdc_rot.sv @@
// Pipelined rotation CORDIC giving cosine and sine of a binary angle, one stage per step.
module hdc_rot #(
	parameter int STEPS = hdc_pkg::STEPS_DEF
) (
	input  logic                          clk,
	input  logic        [hdc_pkg::AW-1:0] bam,
	output logic signed [hdc_pkg::XW-1:0] cs,
	output logic signed [hdc_pkg::XW-1:0] sn
);
	import hdc_pkg::*;

	localparam logic signed [XW-1:0] QTR = 34'sd1073741824;
	localparam logic signed [XW-1:0] HLF = 34'sd2147483648;

	logic signed [XW-1:0] zi;
	logic signed [XW-1:0] z_s0;
	logic                 flip_s0;
	logic signed [XW-1:0] x_s [1:STEPS];
	logic signed [XW-1:0] y_s [1:STEPS];
	logic signed [XW-1:0] z_s [1:STEPS];
	logic                 flip_s [1:STEPS];

	assign zi = XW'($signed(bam));

	always_ff @(posedge clk) begin
		if (zi > QTR) begin
			z_s0    <= zi - HLF;
			flip_s0 <= 1'b1;
		end else if (zi < -QTR) begin
			z_s0    <= zi + HLF;
			flip_s0 <= 1'b1;
		end else begin
			z_s0    <= zi;
			flip_s0 <= 1'b0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [XW-1:0] T = $signed({2'b00, atan_at(5'(i))});
		logic signed [XW-1:0] xp, yp, zp;
		logic                 fp;
		if (i == 0) begin : g_first
			assign xp = $signed(GAIN);
			assign yp = '0;
			assign zp = z_s0;
			assign fp = flip_s0;
		end else begin : g_next
			assign xp = x_s[i];
			assign yp = y_s[i];
			assign zp = z_s[i];
			assign fp = flip_s[i];
		end
		always_ff @(posedge clk) begin
			if (!zp[XW-1]) begin
				x_s[i+1] <= xp - (yp >>> i);
				y_s[i+1] <= yp + (xp >>> i);
				z_s[i+1] <= zp - T;
			end else begin
				x_s[i+1] <= xp + (yp >>> i);
				y_s[i+1] <= yp - (xp >>> i);
				z_s[i+1] <= zp + T;
			end
			flip_s[i+1] <= fp;
		end
	end

	always_ff @(posedge clk) begin
		if (flip_s[STEPS]) begin
			cs <= -x_s[STEPS];
			sn <= -y_s[STEPS];
		end else begin
			cs <= x_s[STEPS];
			sn <= y_s[STEPS];
		end
	end

endmodule

@@ design/hdc_sqrt.sv @@
// Pipelined bitwise integer square root, one result bit per stage.
module hdc_sqrt (
	input  logic                   clk,
	input  logic [hdc_pkg::VW-1:0] v,
	output logic [hdc_pkg::RW-1:0] root
);
	import hdc_pkg::*;

	logic [VW-1:0] v_s [1:RW];
	logic [VW:0]   r_s [1:RW];

	for (genvar i = 0; i < RW; i++) begin : g_step
		localparam logic [VW:0] B = (VW+1)'(1) << (VW - 1 - 2 * i);
		logic [VW-1:0] vp;
		logic [VW:0]   rp, sum;
		if (i == 0) begin : g_first
			assign vp = v;
			assign rp = '0;
		end else begin : g_next
			assign vp = v_s[i];
			assign rp = r_s[i];
		end
		assign sum = rp + B;
		always_ff @(posedge clk) begin
			if ({1'b0, vp} >= sum) begin
				v_s[i+1] <= vp - sum[VW-1:0];
				r_s[i+1] <= (rp >> 1) + B;
			end else begin
				v_s[i+1] <= vp;
				r_s[i+1] <= rp >> 1;
			end
		end
	end

	assign root = r_s[RW][RW-1:0];

endmodule

@@ design/hdc_vec.sv @@
// Pipelined vectoring CORDIC giving the angle of a vector, one stage per step.
module hdc_vec #(
	parameter int STEPS = hdc_pkg::STEPS_DEF
) (
	input  logic                          clk,
	input  logic        [hdc_pkg::RW-1:0] xin,
	input  logic        [hdc_pkg::RW-1:0] yin,
	output logic signed [hdc_pkg::XW-1:0] ang
);
	import hdc_pkg::*;

	logic signed [XW-1:0] x_s [1:STEPS];
	logic signed [XW-1:0] y_s [1:STEPS];
	logic signed [XW-1:0] z_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [XW-1:0] T = $signed({2'b00, atan_at(5'(i))});
		logic signed [XW-1:0] xp, yp, zp;
		if (i == 0) begin : g_first
			assign xp = $signed(XW'(xin));
			assign yp = $signed(XW'(yin));
			assign zp = '0;
		end else begin : g_next
			assign xp = x_s[i];
			assign yp = y_s[i];
			assign zp = z_s[i];
		end
		always_ff @(posedge clk) begin
			if (!yp[XW-1]) begin
				x_s[i+1] <= xp + (yp >>> i);
				y_s[i+1] <= yp - (xp >>> i);
				z_s[i+1] <= zp + T;
			end else begin
				x_s[i+1] <= xp - (yp >>> i);
				y_s[i+1] <= yp + (xp >>> i);
				z_s[i+1] <= zp - T;
			end
		end
	end

	assign ang = z_s[STEPS];

endmodule

@@ design/haversine_distance_top.sv @@
// Top level of the pipelined haversine great-circle distance engine.
//
// Usage: present two points (latitude and longitude in Q22 degrees) on lat_a, lon_a,
// lat_b and lon_b and raise start for one cycle; the beat is taken at that edge.
// busy stays low, so a new beat can be started in every cycle.
// The distance in units of 1/1024 km appears on distance while done is high for
// exactly one cycle. Results leave in the order the beats came in.
// Throughput is one beat per cycle: every unit is a chain of registered stages,
// and the depth is set by the two CORDIC chains and the 31-stage square root.
// Reset clears the valid line, so no done pulse follows reset until new beats
// arrive; the data stages are not reset. The receiver cannot stall the block, so
// each result must be taken in the cycle done is high.
`include "haversine_distance_top_defines.svh"
module haversine_distance_top #(
	parameter int CORDIC_STEPS = hdc_pkg::STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [29:0] lat_a,
	input  logic signed [30:0] lon_a,
	input  logic signed [29:0] lat_b,
	input  logic signed [30:0] lon_b,
	output logic               done,
	output logic        [24:0] distance
);
	import hdc_pkg::*;

	localparam int LAT = 2 * CORDIC_STEPS + 42;

	logic [LAT-1:0] vld_q;
	logic [UW-1:0] u_s1 [0:3];
	logic [AW-1:0] bam [0:3];
	logic signed [XW-1:0] c1, c2, sh, so;
	logic signed [63:0] p_sh, p_so, p_cc, p_t;
	logic signed [31:0] sq1_s2, sq2_s2, cc_s2;
	logic signed [32:0] asum;
	logic [30:0] a_s3;
	logic [RW-1:0] ra, rb;
	logic signed [XW-1:0] ang;
	logic [58:0] pd;
	logic [58:0] pd_s4;
	logic pos_s4;
	logic [59:0] dsum;
	logic [27:0] dq;

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		u_s1[0] <= (UW'(lat_a) <<< 7) + RND_BIAS + BAM_OFS;
		u_s1[1] <= (UW'(lat_b) <<< 7) + RND_BIAS + BAM_OFS;
		u_s1[2] <= ((UW'(lat_b) - UW'(lat_a)) <<< 6) + RND_BIAS + BAM_OFS;
		u_s1[3] <= ((UW'(lon_b) - UW'(lon_a)) <<< 6) + RND_BIAS + BAM_OFS;
	end

	for (genvar k = 0; k < 4; k++) begin : g_bam
		hdc_bam u_bam (
			.clk (clk),
			.u   (u_s1[k]),
			.bam (bam[k])
		);
	end

	hdc_rot #(.STEPS(CORDIC_STEPS)) u_rot_la (.clk(clk), .bam(bam[0]), .cs(c1), .sn());
	hdc_rot #(.STEPS(CORDIC_STEPS)) u_rot_lb (.clk(clk), .bam(bam[1]), .cs(c2), .sn());
	hdc_rot #(.STEPS(CORDIC_STEPS)) u_rot_dl (.clk(clk), .bam(bam[2]), .cs(), .sn(sh));
	hdc_rot #(.STEPS(CORDIC_STEPS)) u_rot_do (.clk(clk), .bam(bam[3]), .cs(), .sn(so));

	assign p_sh = 64'($signed(sh[31:0])) * 64'($signed(sh[31:0]));
	assign p_so = 64'($signed(so[31:0])) * 64'($signed(so[31:0]));
	assign p_cc = 64'($signed(c1[31:0])) * 64'($signed(c2[31:0]));

	always_ff @(posedge clk) begin
		sq1_s2 <= 32'(p_sh >>> 30);
		sq2_s2 <= 32'(p_so >>> 30);
		cc_s2  <= 32'(p_cc >>> 30);
	end

	assign p_t  = 64'(cc_s2) * 64'(sq2_s2);
	assign asum = 33'(sq1_s2) + 33'(p_t >>> 30);

	always_ff @(posedge clk) begin
		if (asum[32]) begin
			a_s3 <= '0;
		end else if (asum > $signed({2'b00, Q30_ONE})) begin
			a_s3 <= Q30_ONE;
		end else begin
			a_s3 <= asum[30:0];
		end
	end

	hdc_sqrt u_sqrt_a (.clk(clk), .v({a_s3, 30'd0}), .root(ra));
	hdc_sqrt u_sqrt_b (.clk(clk), .v({Q30_ONE - a_s3, 30'd0}), .root(rb));

	hdc_vec #(.STEPS(CORDIC_STEPS)) u_vec (
		.clk (clk),
		.xin (rb),
		.yin (ra),
		.ang (ang)
	);

	assign pd = 59'(ang[31:0]) * 59'(DIST_MUL);

	always_ff @(posedge clk) begin
		pd_s4  <= pd;
		pos_s4 <= !ang[XW-1] && (ang != '0);
	end

	assign dsum = 60'(pd_s4) + 60'd2147483648;
	assign dq   = dsum[59:32];

	always_ff @(posedge clk) begin
		if (!pos_s4) begin
			distance <= '0;
		end else if (dq > 28'(DIST_MAX)) begin
			distance <= DIST_MAX;
		end else begin
			distance <= dq[24:0];
		end
	end

	`HDC_ASSERT_IMP(a_lat_fwd, start && !busy, ##LAT done, "beat taken without a result")
	`HDC_ASSERT_IMP(a_lat_back, done, $past(start && !busy, LAT), "result without a beat")
	`HDC_ASSERT_NEVER(a_sat, done && (distance > DIST_MAX), "distance above saturation")

endmodule
